// File: src/rkl_pkg.sv
package rkl_pkg;

   localparam int unsigned KeyCount = 15;

   localparam logic [15:0] DebounceReset = 16'd20;
   localparam logic [15:0] FlashReset    = 16'd1000;
   localparam logic [15:0] RefreshReset  = 16'd10;
   localparam logic [7:0]  DriveReset    = 8'hFF;
   localparam logic [3:0]  FlashBit      = 4'd7;
   localparam logic [15:0] CountMax      = 16'hFFFF;

   localparam logic [3:0] KEY_CODES [KeyCount] = '{
      4'h1, 4'h2, 4'h4, 4'hA, 4'hB, 4'h6, 4'h7, 4'hC,
      4'h9, 4'h3, 4'hE, 4'hD, 4'hF, 4'h8, 4'h5
   };

   localparam logic [3:0] KeyNone     = 4'd0;
   localparam logic [3:0] KeyLastFlip = 4'd8;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_FLASH    = 2'd1,
      CSR_REFRESH  = 2'd2,
      CSR_BLANK    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] count;
      logic        fire;
   } timer_next_type;

   function automatic logic [3:0] decode_key(input logic [3:0] code);
      logic [3:0] key;
      key = KeyNone;
      for (int i = 0; i < KeyCount; i++) begin
         if (KEY_CODES[i] == code) begin
            key = 4'(i + 1);
         end
      end
      return key;
   endfunction

   function automatic timer_next_type timer_step(input logic [15:0] count,
                                                 input logic [15:0] period);
      timer_next_type nxt;
      nxt.count = count;
      nxt.fire  = 1'b0;
      if (count != 16'd0) begin
         if (count == 16'd1) begin
            nxt.count = period;
            nxt.fire  = 1'b1;
         end else begin
            nxt.count = count - 16'd1;
         end
      end
      return nxt;
   endfunction

endpackage

// File: src/rkl_if.sv
interface rkl_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] remote_code;

   modport source(output valid, output remote_code, input ready);
   modport sink(input valid, input remote_code, output ready);
endinterface

interface rkl_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  drive_byte;
   logic [15:0] led_word;
   logic        key_event;
   logic [3:0]  key_number;

   modport source(output valid, output drive_byte, output led_word, output key_event,
                  output key_number, input ready);
   modport sink(input valid, input drive_byte, input led_word, input key_event,
                input key_number, output ready);
endinterface

// File: src/remote_key_led_controller.sv
// Channel | Direction | Payload
// req     | in        | remote_code[3:0]
// rsp     | out       | drive_byte[7:0], led_word[15:0], key_event, key_number[3:0]
// csr     | in        | APB write/read, four registers at 0x0, 0x4, 0x8, 0xC
//
// Each beat passes through the input register and then the result register;
// one beat per cycle sustained while the result side is not stalled.
// The debounce, timer and LED state update as a beat moves into the result register.
// Synchronous active-high reset restores the register defaults and LED state.
// A stalled result holds the result register; the input register fills only while it is empty.
module remote_key_led_controller (
   input  logic        clock,
   input  logic        reset,
   rkl_req_if.sink     req,
   rkl_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0] debounce_ff, flash_period_ff, refresh_period_ff;
   logic        blank_ff;

   logic        in_valid_ff;
   logic [3:0]  in_code_ff;

   logic [15:0] press_count_ff, press_count_in;
   logic        press_lock_ff, press_lock_in;
   logic [15:0] led_ff, led_in;
   logic [15:0] flash_timer_ff, flash_timer_in;
   logic [15:0] refresh_timer_ff, refresh_timer_in;
   logic [7:0]  drive_ff, drive_in;

   logic        out_valid_ff;
   logic        event_ff, event_in;
   logic [3:0]  key_ff, key_in;

   logic        out_load;
   logic        in_load;
   logic        csr_write;
   logic [15:0] count_inc;
   logic [3:0]  key_dec;
   logic [15:0] key_mask;
   rkl_pkg::timer_next_type flash_nxt, refresh_nxt;
   rkl_pkg::csr_index_type  csr_idx;

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign in_load   = !in_valid_ff || out_load;
   assign req.ready = in_load;

   assign csr_idx    = rkl_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         rkl_pkg::CSR_DEBOUNCE: csr_prdata = {16'd0, debounce_ff};
         rkl_pkg::CSR_FLASH:    csr_prdata = {16'd0, flash_period_ff};
         rkl_pkg::CSR_REFRESH:  csr_prdata = {16'd0, refresh_period_ff};
         rkl_pkg::CSR_BLANK:    csr_prdata = {31'd0, blank_ff};
         default:               csr_prdata = 32'd0;
      endcase
   end

   assign count_inc = (press_count_ff != rkl_pkg::CountMax) ? press_count_ff + 16'd1
                                                            : press_count_ff;
   assign key_dec   = rkl_pkg::decode_key(in_code_ff);
   assign key_mask  = (key_dec == rkl_pkg::KeyNone) ? 16'd0
                                                    : 16'd1 << (key_dec - 4'd1);
   assign flash_nxt   = rkl_pkg::timer_step(flash_timer_ff, flash_period_ff);
   assign refresh_nxt = rkl_pkg::timer_step(refresh_timer_ff, refresh_period_ff);

   always_comb begin
      press_count_in = press_count_ff;
      press_lock_in  = press_lock_ff;
      led_in         = led_ff;
      event_in       = 1'b0;
      key_in         = rkl_pkg::KeyNone;
      drive_in       = drive_ff;

      if (in_code_ff == 4'd0) begin
         press_lock_in  = 1'b0;
         press_count_in = 16'd0;
      end else if (!press_lock_ff) begin
         press_count_in = count_inc;
         if (count_inc >= debounce_ff) begin
            press_lock_in = 1'b1;
            event_in      = 1'b1;
            key_in        = key_dec;
            if (key_dec <= rkl_pkg::KeyLastFlip) begin
               led_in = led_ff ^ key_mask;
            end else begin
               led_in = led_ff | key_mask;
            end
         end
      end

      flash_timer_in = flash_nxt.count;
      if (flash_nxt.fire) begin
         led_in[rkl_pkg::FlashBit] = ~led_in[rkl_pkg::FlashBit];
      end

      refresh_timer_in = refresh_nxt.count;
      if (refresh_nxt.fire) begin
         if (blank_ff) begin
            led_in[7:0] = 8'd0;
         end
         drive_in = ~led_in[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff       <= rkl_pkg::DebounceReset;
         flash_period_ff   <= rkl_pkg::FlashReset;
         refresh_period_ff <= rkl_pkg::RefreshReset;
         blank_ff          <= 1'b0;
         in_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         press_count_ff    <= 16'd0;
         press_lock_ff     <= 1'b0;
         led_ff            <= 16'd0;
         flash_timer_ff    <= rkl_pkg::FlashReset;
         refresh_timer_ff  <= rkl_pkg::RefreshReset;
         drive_ff          <= rkl_pkg::DriveReset;
      end else begin
         if (csr_write) begin
            case (csr_idx)
               rkl_pkg::CSR_DEBOUNCE: debounce_ff       <= csr_pwdata[15:0];
               rkl_pkg::CSR_FLASH:    flash_period_ff   <= csr_pwdata[15:0];
               rkl_pkg::CSR_REFRESH:  refresh_period_ff <= csr_pwdata[15:0];
               rkl_pkg::CSR_BLANK:    blank_ff          <= csr_pwdata[0];
               default:               blank_ff          <= blank_ff;
            endcase
         end
         if (in_load) begin
            in_valid_ff <= req.valid;
         end
         if (out_load) begin
            out_valid_ff     <= 1'b1;
            press_count_ff   <= press_count_in;
            press_lock_ff    <= press_lock_in;
            led_ff           <= led_in;
            flash_timer_ff   <= flash_timer_in;
            refresh_timer_ff <= refresh_timer_in;
            drive_ff         <= drive_in;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_code_ff <= req.remote_code;
      end
      if (out_load) begin
         event_ff <= event_in;
         key_ff   <= key_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.drive_byte = drive_ff;
   assign rsp.led_word   = led_ff;
   assign rsp.key_event  = event_ff;
   assign rsp.key_number = key_ff;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int CycleLimit = 1000000;
   localparam int LongHold   = 400;

   localparam logic [15:0] DebounceDefault = 16'd20;
   localparam logic [15:0] FlashDefault    = 16'd1000;
   localparam logic [15:0] RefreshDefault  = 16'd10;

   localparam logic [3:0] KeyOfCode [16] = '{
      4'd0,  4'd1,  4'd2,  4'd10, 4'd3,  4'd15, 4'd6,  4'd7,
      4'd14, 4'd9,  4'd4,  4'd5,  4'd8,  4'd12, 4'd11, 4'd13
   };

   typedef struct packed {
      logic [7:0]  drive_byte;
      logic [15:0] led_word;
      logic        key_event;
      logic [3:0]  key_number;
   } panel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rkl_req_if req_if();
   rkl_rsp_if rsp_if();

   remote_key_led_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [15:0] cfg_debounce;
   logic [15:0] cfg_flash;
   logic [15:0] cfg_refresh;
   logic        cfg_blank;

   logic [15:0] press_count;
   logic        press_held;
   logic [15:0] led_bits;
   logic [15:0] flash_left;
   logic [15:0] refresh_left;
   logic [7:0]  drive_bits;

   logic [3:0] code_q [$];
   panel_type  panel_q [$];

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int cycle_count;
   int hold_left;
   int hold_want;
   int hold_seen;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [16:0] countdown(input logic [15:0] left,
                                             input logic [15:0] period);
      if (left == 16'd0) return {1'b0, left};
      if (left == 16'd1) return {1'b1, period};
      return {1'b0, left - 16'd1};
   endfunction

   function automatic void step_panel(input logic [3:0] code);
      panel_type   exp;
      logic [3:0]  key;
      logic [16:0] tmr;
      exp = '0;
      if (code == 4'd0) begin
         press_held  = 1'b0;
         press_count = 16'd0;
      end else if (!press_held) begin
         if (press_count != 16'hFFFF) press_count = press_count + 16'd1;
         if (press_count >= cfg_debounce) begin
            press_held     = 1'b1;
            key            = KeyOfCode[code];
            exp.key_event  = 1'b1;
            exp.key_number = key;
            if (key >= 4'd1 && key <= 4'd8) begin
               led_bits = led_bits ^ (16'd1 << (key - 4'd1));
            end else if (key >= 4'd9) begin
               led_bits = led_bits | (16'd1 << (key - 4'd1));
            end
         end
      end
      tmr = countdown(flash_left, cfg_flash);
      flash_left = tmr[15:0];
      if (tmr[16]) led_bits[7] = ~led_bits[7];
      tmr = countdown(refresh_left, cfg_refresh);
      refresh_left = tmr[15:0];
      if (tmr[16]) begin
         if (cfg_blank) led_bits[7:0] = 8'd0;
         drive_bits = ~led_bits[7:0];
      end
      exp.drive_byte = drive_bits;
      exp.led_word   = led_bits;
      panel_q.push_back(exp);
   endfunction

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= 100) $display("ERROR at %0t: %s", $time, what);
   endtask

   // driver: hold the beat until taken, then offer the next code
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.remote_code <= 4'd0;
      end else begin
         if (req_if.valid && req_if.ready) step_panel(req_if.remote_code);
         if (!req_if.valid || req_if.ready) begin
            if (code_q.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
               req_if.valid       <= 1'b1;
               req_if.remote_code <= code_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= hold_want;
      end else if (hold_seen != hold_want) begin
         hold_left <= LongHold;
         hold_seen <= hold_want;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (hold_left == 0) && (int'($urandom_range(0, 99)) >= recv_stall_pct);
      end
   end

   // monitor: compare each beat against the oldest predicted panel state
   always @(posedge clock) begin
      panel_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (panel_q.size() == 0) begin
            report_error("result beat with no prediction pending");
         end else begin
            exp = panel_q.pop_front();
            if (rsp_if.drive_byte !== exp.drive_byte)
               report_error($sformatf("drive_byte got %h want %h",
                                      rsp_if.drive_byte, exp.drive_byte));
            if (rsp_if.led_word !== exp.led_word)
               report_error($sformatf("led_word got %h want %h",
                                      rsp_if.led_word, exp.led_word));
            if (rsp_if.key_event !== exp.key_event)
               report_error($sformatf("key_event got %b want %b",
                                      rsp_if.key_event, exp.key_event));
            if (rsp_if.key_number !== exp.key_number)
               report_error($sformatf("key_number got %0d want %0d",
                                      rsp_if.key_number, exp.key_number));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_reg(input rkl_pkg::csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         rkl_pkg::CSR_DEBOUNCE: cfg_debounce = value;
         rkl_pkg::CSR_FLASH:    cfg_flash    = value;
         rkl_pkg::CSR_REFRESH:  cfg_refresh  = value;
         rkl_pkg::CSR_BLANK:    cfg_blank    = value[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] debounce, input logic [15:0] flash,
                             input logic [15:0] refresh, input logic blank_on);
      write_reg(rkl_pkg::CSR_DEBOUNCE, debounce);
      write_reg(rkl_pkg::CSR_FLASH, flash);
      write_reg(rkl_pkg::CSR_REFRESH, refresh);
      write_reg(rkl_pkg::CSR_BLANK, {15'd0, blank_on});
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (code_q.size() != 0 || req_if.valid || panel_q.size() != 0);
   endtask

   // mostly clean presses near the debounce length, the rest single noisy ticks
   task automatic add_random_ticks(input int count);
      int         added;
      int         hold;
      int         gap;
      logic [3:0] code;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 99) < 75) begin
            code = 4'($urandom_range(1, 15));
            hold = int'(cfg_debounce) + int'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0) hold = hold - 2;
            if (hold < 1) hold = 1;
            gap = int'($urandom_range(1, 3));
            repeat (hold) code_q.push_back(code);
            repeat (gap) code_q.push_back(4'd0);
            added = added + hold + gap;
         end else begin
            code_q.push_back(4'($urandom_range(0, 15)));
            added++;
         end
      end
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = 4'd0;
      csr_pwdata         = 32'd0;
      req_if.valid       = 1'b0;
      req_if.remote_code = 4'd0;
      rsp_if.ready       = 1'b0;
      cfg_debounce       = DebounceDefault;
      cfg_flash          = FlashDefault;
      cfg_refresh        = RefreshDefault;
      cfg_blank          = 1'b0;
      press_count        = 16'd0;
      press_held         = 1'b0;
      led_bits           = 16'd0;
      flash_left         = FlashDefault;
      refresh_left       = RefreshDefault;
      drive_bits         = 8'hFF;
      error_count        = 0;
      cycle_count        = 0;
      hold_want          = 0;
      set_idle(0, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // defaults: short presses below the debounce count, refresh at tick ten
      foreach (KeyOfCode[i]) if (i < 11) code_q.push_back(i % 3 == 2 ? 4'd15 : 4'd0);
      code_q[2] = 4'd3;
      code_q[3] = 4'd3;
      wait_idle();

      // toggle keys, set keys, a held key
      set_config(16'd1, 16'd3, 16'd1, 1'b0);
      code_q = '{4'd1, 4'd0, 4'd12, 4'd0, 4'd9, 4'd0, 4'd5, 4'd0, 4'd1, 4'd1, 4'd1, 4'd0};
      wait_idle();

      set_config(16'd2, 16'd7, 16'd3, 1'b0);
      add_random_ticks(100);
      wait_idle();
      add_random_ticks(100);
      wait_idle();

      set_config(16'd1, 16'd1, 16'd1, 1'b1);
      set_idle(70, 0);
      add_random_ticks(200);
      wait_idle();

      // stall the result side long enough to back up the input
      set_config(16'd4, 16'd13, 16'd2, 1'b0);
      set_idle(0, 70);
      add_random_ticks(200);
      hold_want++;
      wait_idle();

      set_config(16'd0, 16'd5, 16'd4, 1'b1);
      set_idle(11, 11);
      add_random_ticks(200);
      wait_idle();

      // long debounce with both timers at their longest period
      set_config(16'd36, 16'hFFFF, 16'hFFFF, 1'b0);
      set_idle(0, 0);
      repeat (40) code_q.push_back(4'd12);
      wait_idle();
      write_reg(rkl_pkg::CSR_FLASH, 16'd3);
      write_reg(rkl_pkg::CSR_REFRESH, 16'd3);
      repeat (12) code_q.push_back(4'd12);
      repeat (18) code_q.push_back(4'd0);
      wait_idle();

      set_config(16'd3, 16'd2, 16'd2, 1'b1);
      set_idle(11, 11);
      add_random_ticks(200);
      wait_idle();

      // zero periods: both timers stop at their next reload
      set_config(16'd5, 16'd0, 16'd0, 1'b0);
      set_idle(70, 0);
      add_random_ticks(150);
      wait_idle();

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
